[rtl/core/dps_pkg.sv]
// Shared types and codes for the dynamic priority scheduler.
// Used by dps_cell, dynamic_priority_scheduler_top and dps_checker; no dependencies.
`default_nettype none

package dps_pkg;

    typedef struct packed {
        logic        [7:0] id;
        logic signed [7:0] prio;
        logic        [7:0] need;
        logic        [7:0] passed;
    } entry_t;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_POP    = 2'd2;

    // Command broadcast to every cell of the queue
    typedef struct packed {
        cell_op_t op;
        entry_t   entry;
    } cell_cmd_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_ADDED    = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_REQUEUED = 3'd2;
    localparam status_t ST_FINISHED = 3'd3;
    localparam status_t ST_IDLE     = 3'd4;

    localparam logic signed [7:0] PRIO_MIN = 8'sh80;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

endpackage

`default_nettype wire

[rtl/core/dynamic_priority_scheduler_top.sv]
// An add or a finishing tick shows its result in the cycle after acceptance.
// A tick that requeues shows its result the same way, then stalls the input in the
// S_REQUEUE state while it reinserts. Adds, idle ticks and finishing ticks leave the input
// free for the next transaction; a result held by out_stall stalls the input until taken.
// Reset (rst_n, async, active low) empties the queue and clears out_valid;
// entry payloads are not cleared, only the fill count marks which cells are live.
`default_nettype none

module dynamic_priority_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              action,
    input  wire logic        [7:0] proc_id,
    input  wire logic signed [7:0] start_priority,
    input  wire logic        [7:0] need_time,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic             [2:0] status,
    output logic             [7:0] run_id,
    output logic signed      [7:0] run_priority,
    output logic             [7:0] run_passed,
    output logic             [4:0] queue_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Controller state: idle, or reinsert the entry popped by the last tick
    localparam logic S_IDLE    = 1'b0;
    localparam logic S_REQUEUE = 1'b1;

    logic            state_reg,  state_next;
    logic [CW-1:0]   count_reg,  count_next;
    dps_pkg::entry_t pend_reg,   pend_next;

    logic                   out_valid_reg, out_valid_next;
    dps_pkg::status_t       status_reg,    status_next;
    logic             [7:0] run_id_reg,    run_id_next;
    logic signed      [7:0] run_prio_reg,  run_prio_next;
    logic             [7:0] run_passed_reg, run_passed_next;
    logic             [4:0] qcount_reg,    qcount_next;

    dps_pkg::cell_cmd_t cmd;
    dps_pkg::entry_t    cell_entry [QUEUE_DEPTH];
    logic               cell_keep  [QUEUE_DEPTH];
    logic               cell_valid [QUEUE_DEPTH];

    dps_pkg::entry_t    head;
    dps_pkg::entry_t    new_entry;
    logic         [7:0] head_passed_inc;
    logic               accept;
    logic               full;
    logic        [31:0] count_dec_ext;
    logic        [31:0] count_inc_ext;
    logic        [31:0] count_ext;

    // Stall while reinserting, or while a result waits and the sink holds it
    assign in_stall = (state_reg == S_REQUEUE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(QUEUE_DEPTH));

    assign head            = cell_entry[0];
    assign head_passed_inc = head.passed + 8'd1;
    assign count_ext       = 32'(count_reg);
    assign count_inc_ext   = 32'(count_reg) + 32'd1;
    assign count_dec_ext   = 32'(count_reg) - 32'd1;

    always_comb
    begin
        new_entry.id     = proc_id;
        new_entry.prio   = start_priority;
        new_entry.need   = (need_time == 8'd0) ? 8'd1 : need_time;
        new_entry.passed = 8'd0;
    end

    // The queue: cell i is live while i < count
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            assign cell_valid[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_head
                dps_cell u_cell (
                    .clk             (clk),
                    .cmd             (cmd),
                    .valid_here      (cell_valid[gi]),
                    .keep_prev       (1'b1),
                    .entry_prev      (cmd.entry),
                    .entry_following (cell_entry[(QUEUE_DEPTH > 1) ? 1 : 0]),
                    .entry_q         (cell_entry[gi]),
                    .keep            (cell_keep[gi])
                );
            end
            else if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                // Nothing behind the tail: a pop leaves it as it is
                dps_cell u_cell (
                    .clk             (clk),
                    .cmd             (cmd),
                    .valid_here      (cell_valid[gi]),
                    .keep_prev       (cell_keep[gi-1]),
                    .entry_prev      (cell_entry[gi-1]),
                    .entry_following (cell_entry[gi]),
                    .entry_q         (cell_entry[gi]),
                    .keep            (cell_keep[gi])
                );
            end
            else
            begin : g_mid
                dps_cell u_cell (
                    .clk             (clk),
                    .cmd             (cmd),
                    .valid_here      (cell_valid[gi]),
                    .keep_prev       (cell_keep[gi-1]),
                    .entry_prev      (cell_entry[gi-1]),
                    .entry_following (cell_entry[gi+1]),
                    .entry_q         (cell_entry[gi]),
                    .keep            (cell_keep[gi])
                );
            end
        end
    endgenerate

    // Controller: pick the cell command, the next count and the result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        cmd.op          = dps_pkg::OP_HOLD;
        cmd.entry       = new_entry;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        run_id_next     = run_id_reg;
        run_prio_next   = run_prio_reg;
        run_passed_next = run_passed_reg;
        qcount_next     = qcount_reg;

        priority if (state_reg == S_REQUEUE)
        begin
            // Reinsert the entry popped last cycle
            cmd.op     = dps_pkg::OP_INSERT;
            cmd.entry  = pend_reg;
            count_next = count_inc_ext[CW-1:0];
            state_next = S_IDLE;
        end
        else if (accept)
        begin
            out_valid_next  = 1'b1;
            run_id_next     = 8'd0;
            run_prio_next   = 8'sd0;
            run_passed_next = 8'd0;
            if (action == dps_pkg::ACT_ADD)
            begin
                if (full)
                begin
                    status_next = dps_pkg::ST_FULL;
                    qcount_next = count_ext[4:0];
                end
                else
                begin
                    cmd.op      = dps_pkg::OP_INSERT;
                    count_next  = count_inc_ext[CW-1:0];
                    status_next = dps_pkg::ST_ADDED;
                    qcount_next = count_inc_ext[4:0];
                end
            end
            else if (count_reg == '0)
            begin
                status_next = dps_pkg::ST_IDLE;
                qcount_next = 5'd0;
            end
            else
            begin
                // Pop the head, advance its run count
                cmd.op          = dps_pkg::OP_POP;
                count_next      = count_dec_ext[CW-1:0];
                run_id_next     = head.id;
                run_prio_next   = head.prio;
                run_passed_next = head_passed_inc;
                if (head_passed_inc == head.need)
                begin
                    status_next = dps_pkg::ST_FINISHED;
                    qcount_next = count_dec_ext[4:0];
                end
                else
                begin
                    status_next      = dps_pkg::ST_REQUEUED;
                    qcount_next      = count_ext[4:0];
                    pend_next.id     = head.id;
                    pend_next.prio   = (head.prio == dps_pkg::PRIO_MIN) ?
                                       head.prio : head.prio - 8'sd1;
                    pend_next.need   = head.need;
                    pend_next.passed = head_passed_inc;
                    state_next       = S_REQUEUE;
                end
            end
        end
        else
        begin
            // Nothing accepted: hold the queue and the controller
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg       <= pend_next;
        status_reg     <= status_next;
        run_id_reg     <= run_id_next;
        run_prio_reg   <= run_prio_next;
        run_passed_reg <= run_passed_next;
        qcount_reg     <= qcount_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign run_id       = run_id_reg;
    assign run_priority = run_prio_reg;
    assign run_passed   = run_passed_reg;
    assign queue_count  = qcount_reg;

endmodule

`default_nettype wire

[rtl/core/dps_cell.sv]
// One slot of the sorted ready queue: holds an entry, shifts with its neighbors.
// Depends on dps_pkg.
`default_nettype none

module dps_cell (
    input  wire logic              clk,
    input  wire dps_pkg::cell_cmd_t cmd,
    input  wire logic              valid_here,
    input  wire logic              keep_prev,
    input  wire dps_pkg::entry_t   entry_prev,
    input  wire dps_pkg::entry_t   entry_following,
    output dps_pkg::entry_t        entry_q,
    output logic                   keep
);

    dps_pkg::entry_t entry_reg;
    dps_pkg::entry_t entry_next;

    // Hold the slot when it outranks or ties the incoming entry
    assign keep = valid_here && (entry_reg.prio >= cmd.entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            dps_pkg::OP_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = keep_prev ? cmd.entry : entry_prev;
                end
            end
            dps_pkg::OP_POP:
            begin
                entry_next = entry_following;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

`default_nettype wire

[rtl/core/dps_checker.sv]
// Port-level checks for dynamic_priority_scheduler_top, attached by bind.
// Depends on dps_pkg.
`default_nettype none

module dps_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic        [2:0] status,
    input wire logic        [7:0] run_id,
    input wire logic        [7:0] run_passed,
    input wire logic        [4:0] queue_count
);

    // A held result blocks new transactions
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted while result held");

    // A held result stays
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("held result changed");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == dps_pkg::ST_IDLE) |-> (queue_count == 5'd0 && run_id == 8'd0))
        else $error("idle tick with non-empty queue");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == dps_pkg::ST_FULL) |->
            (QUEUE_DEPTH > 31 || 32'(queue_count) == QUEUE_DEPTH))
        else $error("full flagged below depth");

    a_ran_passed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == dps_pkg::ST_REQUEUED || status == dps_pkg::ST_FINISHED))
            |-> (run_passed != 8'd0 || status == dps_pkg::ST_REQUEUED))
        else $error("finished process with zero run count");

endmodule

bind dynamic_priority_scheduler_top dps_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .run_id      (run_id),
    .run_passed  (run_passed),
    .queue_count (queue_count)
);

`default_nettype wire
